### design/tbpc_pkg.sv
package tbpc_pkg;

	// Configuration register indexes and width
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT = 2'd2;

	// Low bit of the press event code: press kind
	localparam logic EV_SHORT = 1'b0;
	localparam logic EV_LONG = 1'b1;

	// Live configuration values
	typedef struct packed {
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] short_limit_ticks;
		logic [CFG_W-1:0] long_limit_ticks;
	} cfg_t;

	// Result of one processed request
	typedef struct packed {
		logic       valid;
		logic [1:0] code;
	} evt_t;

endpackage

### design/two_button_press_classifier.sv
// The press event of an accepted tick goes from the input register through the
// result register to the output; a stalled, full result register holds it back.
// Throughput: one tick per cycle unless out_stall holds a full result register;
// the per-tick counter update and limit compare lie between the two registers.
// Reset (arst_n low, asynchronous): idle, no marks pending, both buttons seen as
// released, counter zero, registers back to 50 / 800 / 2000 ticks.
module two_button_press_classifier #(
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          button_one_level,
	input  logic                          button_two_level,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    press_event,
	input  logic                          wr_en,
	input  logic [tbpc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [tbpc_pkg::CFG_W-1:0]     wr_data
);
	import tbpc_pkg::*;

	cfg_t cfg;
	evt_t evt;
	logic out_free;

	tbpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	tbpc_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.button_one_level (button_one_level),
		.button_two_level (button_two_level),
		.cfg              (cfg),
		.out_free         (out_free),
		.evt              (evt)
	);

	tbpc_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.press_event (press_event)
	);

endmodule

### design/tbpc_cfg_regs.sv
module tbpc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [tbpc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [tbpc_pkg::CFG_W-1:0]     wr_data,
	output tbpc_pkg::cfg_t                cfg
);
	import tbpc_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= CFG_W'(50);
			cfg_q.short_limit_ticks <= CFG_W'(800);
			cfg_q.long_limit_ticks <= CFG_W'(2000);
		end else if (wr_en) begin
			case (wr_index)
				REG_DEBOUNCE: cfg_q.debounce_ticks <= wr_data;
				REG_SHORT_LIMIT: cfg_q.short_limit_ticks <= wr_data;
				REG_LONG_LIMIT: cfg_q.long_limit_ticks <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/tbpc_core.sv
module tbpc_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           button_one_level,
	input  logic           button_two_level,
	input  tbpc_pkg::cfg_t cfg,
	input  logic           out_free,
	output tbpc_pkg::evt_t evt
);
	import tbpc_pkg::*;

	localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DEBOUNCE = 2'd1;
	localparam logic [1:0] PH_MEASURE = 2'd2;
	localparam logic [1:0] PH_WAIT_RELEASE = 2'd3;

	logic                  valid_s1;
	logic                  lv1_s1;
	logic                  lv2_s1;
	logic                  advance;

	logic [1:0]            phase_q, phase_n;
	logic                  chosen_q, chosen_n;
	logic                  pend_one_q, pend_one_n;
	logic                  pend_two_q, pend_two_n;
	logic [1:0]            prev_q;
	logic [COUNT_BITS-1:0] cnt_q, cnt_n, cnt_inc;
	logic                  chosen_level;
	logic                  p1, p2;
	logic                  emit;
	logic                  emit_kind;

	assign advance = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register: hold the sampled levels until processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			lv1_s1 <= button_one_level;
			lv2_s1 <= button_two_level;
		end
	end

	// Next state for one tick
	always_comb begin
		p1 = pend_one_q | (prev_q[0] & ~lv1_s1);
		p2 = pend_two_q | (prev_q[1] & ~lv2_s1);
		chosen_level = chosen_q ? lv2_s1 : lv1_s1;
		cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
		phase_n = phase_q;
		chosen_n = chosen_q;
		pend_one_n = p1;
		pend_two_n = p2;
		cnt_n = cnt_q;
		emit = 1'b0;
		emit_kind = EV_SHORT;
		case (phase_q)
			PH_IDLE: begin
				if (p1 || p2) begin
					chosen_n = ~p1;
					pend_one_n = 1'b0;
					pend_two_n = 1'b0;
					cnt_n = '0;
					phase_n = PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE: begin
				cnt_n = cnt_inc;
				if (CMP_W'(cnt_inc) >= CMP_W'(cfg.debounce_ticks)) begin
					cnt_n = '0;
					phase_n = PH_MEASURE;
				end
			end
			PH_MEASURE: begin
				if (chosen_level) begin
					emit = CMP_W'(cnt_q) < CMP_W'(cfg.short_limit_ticks);
					emit_kind = EV_SHORT;
					phase_n = PH_IDLE;
				end else begin
					cnt_n = cnt_inc;
					if (CMP_W'(cnt_inc) >= CMP_W'(cfg.long_limit_ticks)) begin
						phase_n = PH_WAIT_RELEASE;
					end
				end
			end
			default: begin
				if (chosen_level) begin
					emit = 1'b1;
					emit_kind = EV_LONG;
					phase_n = PH_IDLE;
				end
			end
		endcase
	end

	// Advance the classifier state once per processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			chosen_q <= 1'b0;
			pend_one_q <= 1'b0;
			pend_two_q <= 1'b0;
			prev_q <= 2'b11;
			cnt_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			chosen_q <= chosen_n;
			pend_one_q <= pend_one_n;
			pend_two_q <= pend_two_n;
			prev_q <= {lv2_s1, lv1_s1};
			cnt_q <= cnt_n;
		end
	end

	assign evt.valid = advance && emit;
	assign evt.code = {chosen_q, emit_kind};

endmodule

### design/tbpc_out_reg.sv
module tbpc_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  tbpc_pkg::evt_t evt,
	output logic           out_free,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     press_event
);
	import tbpc_pkg::*;

	logic       out_valid_q;
	logic [1:0] press_q;

	assign out_free = !out_valid_q || !out_stall;

	// Load a new result whenever the slot is empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && evt.valid) begin
			press_q <= evt.code;
		end
	end

	assign out_valid = out_valid_q;
	assign press_event = press_q;

endmodule
